@@ hdl/u16d_pkg.sv @@
// Shared types and constants of the UTF-16 decoder.
package u16d_pkg;

  localparam int unsigned UNIT_W        = 16;
  localparam int unsigned CP_W          = 21;
  localparam int unsigned HALF_W        = 10;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0]   CP_SUPP_BASE   = 21'h010000;

  // Surrogate ranges, compared on the top six bits of a unit
  localparam logic [5:0] TAG_HIGH = 6'b110110;
  localparam logic [5:0] TAG_LOW  = 6'b110111;

  // One queued operation: an optional leading replacement, then the main result
  typedef struct packed {
    logic            lead_rep;    // emit U+FFFD for a dropped high surrogate first
    logic [CP_W-1:0] code_point;  // main result
    logic            replaced;    // main result is a replacement
    logic            string_end;  // item closes the string
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

endpackage

@@ hdl/u16d_if.sv @@
// Valid/ready channel interfaces for code units and decoded code points.
interface utf16_in_if;
  logic                          valid;
  logic                          ready;
  logic [u16d_pkg::UNIT_W-1:0]   code_unit;
  logic                          string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink   (input valid, input code_unit, input string_end, output ready);
endinterface

interface utf16_out_if;
  logic                          valid;
  logic                          ready;
  logic [u16d_pkg::CP_W-1:0]     code_point;
  logic                          replaced;
  logic                          run_last;
  logic                          string_last;

  modport source (output valid, output code_point, output replaced, output run_last,
                  output string_last, input ready);
  modport sink   (input valid, input code_point, input replaced, input run_last,
                  input string_last, output ready);
endinterface

@@ hdl/u16d_front.sv @@
// Front end: accepts code units, tracks the pending high surrogate, queues operations.
module u16d_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [u16d_pkg::UNIT_W-1:0] in_code_unit,
  input  logic                        in_string_end,
  input  logic                        q_full,
  output logic                        q_push,
  output u16d_pkg::op_t               q_op
);

  logic                          pend_r, pend_nxt;
  logic [u16d_pkg::HALF_W-1:0]   hbits_r, hbits_nxt;
  logic                          accept;
  logic                          is_high, is_low;
  logic                          main_vld;
  logic [u16d_pkg::CP_W-1:0]     main_cp;
  logic                          main_rep;
  logic [u16d_pkg::CP_W-1:0]     pair_cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (in_code_unit[15:10] == u16d_pkg::TAG_HIGH);
  assign is_low   = (in_code_unit[15:10] == u16d_pkg::TAG_LOW);
  assign pair_cp  = u16d_pkg::CP_SUPP_BASE +
                    {1'b0, hbits_r, in_code_unit[u16d_pkg::HALF_W-1:0]};

  // Classify the unit against the held surrogate
  always_comb begin
    pend_nxt  = pend_r;
    hbits_nxt = hbits_r;
    q_push    = 1'b0;
    q_op      = '0;
    main_vld  = 1'b1;
    main_cp   = {5'd0, in_code_unit};
    main_rep  = 1'b0;
    if (pend_r && is_low) begin
      main_cp  = pair_cp;
    end else if (is_high) begin
      main_cp  = u16d_pkg::CP_REPLACEMENT;
      main_rep = 1'b1;
      main_vld = in_string_end;
    end else if (is_low) begin
      main_cp  = u16d_pkg::CP_REPLACEMENT;
      main_rep = 1'b1;
    end
    q_op.string_end = in_string_end;
    if (pend_r && is_low) begin
      q_op.code_point = main_cp;
    end else if (main_vld) begin
      q_op.lead_rep   = pend_r;
      q_op.code_point = main_cp;
      q_op.replaced   = main_rep;
    end else begin
      // buffered high surrogate; an older one only yields its replacement
      q_op.code_point = u16d_pkg::CP_REPLACEMENT;
      q_op.replaced   = 1'b1;
    end
    if (accept) begin
      q_push    = main_vld || pend_r;
      pend_nxt  = is_high && !in_string_end && !(pend_r && is_low);
      hbits_nxt = pend_nxt ? in_code_unit[u16d_pkg::HALF_W-1:0] : '0;
    end
  end

  // Surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      hbits_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      hbits_r <= hbits_nxt;
    end
  end

endmodule

@@ hdl/u16d_fifo.sv @@
// Small register queue between front and back end.
module u16d_fifo #(
  parameter int unsigned DEPTH = u16d_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u16d_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output u16d_pkg::op_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u16d_pkg::op_t     mem_r [DEPTH];
  logic [AW-1:0]     wptr_r, rptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/u16d_back.sv @@
// Back end: expands queued operations into results through an output register.
module u16d_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  u16d_pkg::op_t             q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [u16d_pkg::CP_W-1:0] out_code_point,
  output logic                      out_replaced,
  output logic                      out_run_last,
  output logic                      out_string_last
);

  logic                      vld_r;
  logic                      lead_done_r;
  logic [u16d_pkg::CP_W-1:0] cp_r;
  logic                      rep_r, run_r, str_r;
  logic                      load;
  logic                      lead;

  assign load  = (!vld_r || out_ready) && !q_empty;
  assign lead  = q_head.lead_rep && !lead_done_r;
  assign q_pop = load && !lead;

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      lead_done_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r       <= 1'b1;
        lead_done_r <= lead;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Result payload: leading replacement first, then the main result
  always_ff @(posedge clk) begin
    if (load) begin
      if (lead) begin
        cp_r  <= u16d_pkg::CP_REPLACEMENT;
        rep_r <= 1'b1;
        run_r <= 1'b0;
        str_r <= 1'b0;
      end else begin
        cp_r  <= q_head.code_point;
        rep_r <= q_head.replaced;
        run_r <= 1'b1;
        str_r <= q_head.string_end;
      end
    end
  end

  assign out_valid       = vld_r;
  assign out_code_point  = cp_r;
  assign out_replaced    = rep_r;
  assign out_run_last    = run_r;
  assign out_string_last = str_r;

endmodule

@@ hdl/utf16_decoder_top.sv @@
// Top level of the streaming UTF-16 to code point decoder.
// Takes one UTF-16 code unit per cycle while in_ready is high and delivers
// decoded code points, one result per cycle while the sink is ready. A
// surrogate pair yields one result for two units, a buffered high surrogate
// yields none for its unit, and a high surrogate that is dropped in front of
// another unit yields an extra U+FFFD, so that unit yields two results. The
// front end classifies units in the accepting cycle into queued operations,
// which the back end expands into the output register that drives out_valid.
// QUEUE_DEPTH (at least 2) sets how much stall on the output side the input
// side absorbs before in_ready drops.
module utf16_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u16d_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  utf16_in_if.sink   in_ch,
  utf16_out_if.source out_ch
);

  logic          q_push, q_pop, q_full, q_empty;
  u16d_pkg::op_t q_op, q_head;

  // Classification and surrogate tracking
  u16d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_code_unit  (in_ch.code_unit),
    .in_string_end (in_ch.string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_op)
  );

  // Operation queue
  u16d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  // Result generation
  u16d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_code_point  (out_ch.code_point),
    .out_replaced    (out_ch.replaced),
    .out_run_last    (out_ch.run_last),
    .out_string_last (out_ch.string_last)
  );

endmodule
